### hdl/sma_pkg.sv
`timescale 1ns / 1ps

package sma_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WLEN_BITS   = 7;
    localparam int SHIFT_BITS  = 6;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic REG_SHIFT      = 1'b1;

    localparam logic [WLEN_BITS-1:0]  WLEN_RESET  = 7'd1;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 6'd0;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_column;
    } sample_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          last_of_run;
        logic                          short_column_error;
    } result_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_FL_STEP,
        ST_FL_UPD,
        ST_DIV,
        ST_PUT
    } sma_state_t;

endpackage

### hdl/sma_ram.sv
`timescale 1ns / 1ps

module sma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/shifted_moving_average.sv
`timescale 1ns / 1ps

// Shifted boxcar moving average over columns of signed samples. The last
// samples of a column sit in a history RAM of MAX_WINDOW entries next to a
// running sum; each item passes an accept state and a read-modify-write
// state, and every average it yields goes through a restoring divider (one
// quotient bit a cycle) and then to the output register, waiting while that
// register is still full. At the end of a column up to shift flushed averages
// follow the same path. A new sample is taken only in the accept state, once
// the last one and all its averages are through. The divider sets the
// rate. Registers: window_len at byte address 0, shift at byte address 4.

module shifted_moving_average
    import sma_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // sample channel
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  sample_item_t           sample_data,
    // result channel
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_item_t           result_data,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_BITS-1:0]  paddr,
    input  logic [PDATA_BITS-1:0]  pwdata,
    output logic [PDATA_BITS-1:0]  prdata,
    output logic                   pready
);

    localparam int AW       = $clog2(MAX_WINDOW);
    localparam int DW       = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS = SAMPLE_BITS + AW + 1;
    localparam int CW       = $clog2(SUM_BITS);
    localparam int WW       = (DW > WLEN_BITS) ? DW : WLEN_BITS;

    localparam logic [AW:0]   MAXV = (AW+1)'(MAX_WINDOW);
    localparam logic [WW-1:0] MAXW = WW'(MAX_WINDOW);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [WLEN_BITS-1:0]  window_len_reg;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WLEN_RESET;
            shift_reg      <= SHIFT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WINDOW_LEN: window_len_reg <= pwdata[WLEN_BITS-1:0];
                REG_SHIFT:      shift_reg      <= pwdata[SHIFT_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW_LEN: prdata = PDATA_BITS'(window_len_reg);
            REG_SHIFT:      prdata = PDATA_BITS'(shift_reg);
        endcase
    end

    // effective window and shift
    logic [WW-1:0] wl_ext;
    logic [WW-1:0] w_wide;
    logic [WW-1:0] sh_ext;
    logic [WW-1:0] s_wide;
    logic [DW-1:0] w_eff;
    logic [DW-1:0] s_eff;

    assign wl_ext = WW'(window_len_reg);
    assign sh_ext = WW'(shift_reg);
    assign w_wide = (wl_ext == '0) ? WW'(1) : ((wl_ext > MAXW) ? MAXW : wl_ext);
    assign s_wide = (sh_ext < w_wide) ? sh_ext : (w_wide - WW'(1));
    assign w_eff  = DW'(w_wide);
    assign s_eff  = DW'(s_wide);

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    sma_state_t                    state_reg, state_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [DW-1:0]                 seen_reg, seen_next;
    logic [AW-1:0]                 wi_reg, wi_next;
    logic [AW-1:0]                 tr_reg, tr_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                          eoc_reg, eoc_next;
    logic [DW-1:0]                 w_reg, w_next;
    logic [DW-1:0]                 s_reg, s_next;
    logic [DW-1:0]                 cnt_reg, cnt_next;
    logic [DW-1:0]                 miss_reg, miss_next;
    logic [DW-1:0]                 len_reg, len_next;
    logic [DW-1:0]                 left_reg, left_next;
    logic [SUM_BITS-1:0]           dq_reg, dq_next;
    logic [DW-1:0]                 drem_reg, drem_next;
    logic [DW-1:0]                 dvsr_reg, dvsr_next;
    logic                          dneg_reg, dneg_next;
    logic [CW-1:0]                 dcnt_reg, dcnt_next;
    logic                          last_reg, last_next;
    logic                          err_reg, err_next;
    result_item_t                  out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    // history RAM
    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    sma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_reg),
        .wdata (x_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] v);
        return (v >= MAXV) ? AW'(v - MAXV) : AW'(v);
    endfunction

    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [DW-1:0]              cnt_eff;
        logic                       full;
        logic [DW-1:0]              cnt_new;
        logic signed [SUM_BITS-1:0] x_ext;
        logic signed [SUM_BITS-1:0] rd_ext;
        logic signed [SUM_BITS-1:0] upd_sum;
        logic signed [SUM_BITS-1:0] fl_sum;
        logic                       short_col;
        logic [DW-1:0]              flush_n;
        logic [AW-1:0]              wi_inc;
        logic                       div_start;
        logic [SUM_BITS-1:0]        div_dividend;
        logic [DW-1:0]              div_divisor;
        logic [DW:0]                rem_shift;
        logic                       ge;
        logic [SUM_BITS-1:0]        quot;

        state_next     = state_reg;
        sum_next       = sum_reg;
        seen_next      = seen_reg;
        wi_next        = wi_reg;
        tr_next        = tr_reg;
        x_next         = x_reg;
        eoc_next       = eoc_reg;
        w_next         = w_reg;
        s_next         = s_reg;
        cnt_next       = cnt_reg;
        miss_next      = miss_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        dq_next        = dq_reg;
        drem_next      = drem_reg;
        dvsr_next      = dvsr_reg;
        dneg_next      = dneg_reg;
        dcnt_next      = dcnt_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result_ready;
        ram_we         = 1'b0;
        ram_raddr      = tr_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = len_reg;

        cnt_eff   = (seen_reg < w_eff) ? seen_reg : w_eff;
        full      = (cnt_reg == w_reg);
        cnt_new   = full ? w_reg : (cnt_reg + DW'(1));
        x_ext     = {{(SUM_BITS-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg};
        rd_ext    = {{(SUM_BITS-SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
        upd_sum   = sum_reg + x_ext - (full ? rd_ext : '0);
        fl_sum    = sum_reg - rd_ext;
        short_col = eoc_reg && (cnt_new < s_reg);
        flush_n   = (eoc_reg && !short_col) ? s_reg : '0;
        wi_inc    = wrap_idx({1'b0, wi_reg} + (AW+1)'(1));

        rem_shift = {drem_reg, dq_reg[SUM_BITS-1]};
        ge        = (rem_shift >= {1'b0, dvsr_reg});
        quot      = dneg_reg ? (~dq_reg + SUM_BITS'(1)) : dq_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // fetch the sample leaving a full window
                ram_raddr = wrap_idx({1'b0, wi_reg} + MAXV - (AW+1)'(w_eff));
                if (sample_valid)
                begin
                    x_next     = sample_data.sample;
                    eoc_next   = sample_data.end_of_column;
                    w_next     = w_eff;
                    s_next     = s_eff;
                    cnt_next   = cnt_eff;
                    state_next = ST_UPD;
                end
            end

            ST_UPD:
            begin
                ram_we    = 1'b1;
                wi_next   = wi_inc;
                seen_next = eoc_reg ? '0 : cnt_new;
                sum_next  = (eoc_reg && (short_col || flush_n == '0)) ? '0 : upd_sum;
                left_next = flush_n;
                miss_next = w_reg - cnt_new;
                len_next  = cnt_new;
                tr_next   = wrap_idx({1'b0, wi_inc} + MAXV - (AW+1)'(cnt_new));
                if (short_col)
                begin
                    dq_next    = '0;
                    dneg_next  = 1'b0;
                    last_next  = 1'b1;
                    err_next   = 1'b1;
                    state_next = ST_PUT;
                end
                else if (cnt_reg >= s_reg)
                begin
                    div_start    = 1'b1;
                    div_dividend = upd_sum;
                    div_divisor  = cnt_new;
                    last_next    = (flush_n == '0);
                end
                else if (flush_n != '0)
                begin
                    state_next = ST_FL_STEP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_FL_STEP:
            begin
                // unfilled window positions go first, divisor unchanged
                if (miss_reg != '0)
                begin
                    miss_next    = miss_reg - DW'(1);
                    left_next    = left_reg - DW'(1);
                    last_next    = (left_reg == DW'(1));
                    div_start    = 1'b1;
                    div_dividend = sum_reg;
                    div_divisor  = len_reg;
                    if (left_reg == DW'(1))
                    begin
                        sum_next = '0;
                    end
                end
                else
                begin
                    state_next = ST_FL_UPD;
                end
            end

            ST_FL_UPD:
            begin
                tr_next      = wrap_idx({1'b0, tr_reg} + (AW+1)'(1));
                len_next     = len_reg - DW'(1);
                left_next    = left_reg - DW'(1);
                last_next    = (left_reg == DW'(1));
                div_start    = 1'b1;
                div_dividend = fl_sum;
                div_divisor  = len_reg - DW'(1);
                sum_next     = (left_reg == DW'(1)) ? '0 : fl_sum;
            end

            ST_DIV:
            begin
                drem_next = ge ? DW'(rem_shift - {1'b0, dvsr_reg}) : DW'(rem_shift);
                dq_next   = {dq_reg[SUM_BITS-2:0], ge};
                dcnt_next = dcnt_reg - CW'(1);
                if (dcnt_reg == '0)
                begin
                    state_next = ST_PUT;
                end
            end

            ST_PUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.average            = quot[SAMPLE_BITS-1:0];
                    out_next.last_of_run        = last_reg;
                    out_next.short_column_error = err_reg;
                    out_valid_next              = 1'b1;
                    state_next = (left_reg != '0) ? ST_FL_STEP : ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (div_start)
        begin
            dneg_next  = div_dividend[SUM_BITS-1];
            dq_next    = div_dividend[SUM_BITS-1] ? (~div_dividend + SUM_BITS'(1))
                                                  : div_dividend;
            drem_next  = '0;
            dvsr_next  = div_divisor;
            dcnt_next  = CW'(SUM_BITS - 1);
            err_next   = 1'b0;
            state_next = ST_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            seen_reg      <= '0;
            wi_reg        <= '0;
            tr_reg        <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            wi_reg        <= wi_next;
            tr_reg        <= tr_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        eoc_reg  <= eoc_next;
        w_reg    <= w_next;
        s_reg    <= s_next;
        cnt_reg  <= cnt_next;
        miss_reg <= miss_next;
        len_reg  <= len_next;
        dq_reg   <= dq_next;
        drem_reg <= drem_next;
        dvsr_reg <= dvsr_next;
        dneg_reg <= dneg_next;
        dcnt_reg <= dcnt_next;
        last_reg <= last_next;
        err_reg  <= err_next;
        out_reg  <= out_next;
    end

endmodule

### verif/sma_average_checker.sv
`timescale 1ns / 1ps

module sma_average_checker
    import sma_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  sample_ready,
    input  sample_item_t          sample_data,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_item_t          result_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatch_count,
    output int                    pending_count,
    output int                    checked_count
);

    localparam int MAX_REPORTS = 40;

    logic [WLEN_BITS-1:0]          window_reg;
    logic [SHIFT_BITS-1:0]         shift_reg;
    logic signed [SAMPLE_BITS-1:0] history [MAX_WINDOW];
    longint                        column_sum;
    int                            samples_in_window;
    int                            write_ptr;
    result_item_t                  expected_averages [$];

    function automatic void push_average(longint sum, longint divisor);
        result_item_t avg;
        avg.average            = SAMPLE_BITS'(sum / divisor);
        avg.last_of_run        = 1'b0;
        avg.short_column_error = 1'b0;
        expected_averages.push_back(avg);
    endfunction

    function automatic void predict_averages(sample_item_t item);
        int           w;
        int           s;
        int           cnt;
        int           trail;
        int           missing;
        int           queued;
        longint       len;
        longint       x;
        result_item_t avg;
        w = window_reg;
        if (w < 1)
            w = 1;
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;
        s = (shift_reg < w) ? int'(shift_reg) : w - 1;
        // a window shrunk mid-column clamps the count, the sum is kept as is
        cnt = (samples_in_window < w) ? samples_in_window : w;
        x = $signed(item.sample);
        queued = expected_averages.size();

        if (cnt < s)
        begin
            column_sum += x;
            cnt++;
        end
        else if (cnt < w)
        begin
            column_sum += x;
            cnt++;
            push_average(column_sum, cnt);
        end
        else
        begin
            column_sum -= history[(write_ptr + MAX_WINDOW - w) % MAX_WINDOW];
            column_sum += x;
            push_average(column_sum, w);
        end
        history[write_ptr] = item.sample;
        write_ptr = (write_ptr + 1) % MAX_WINDOW;
        samples_in_window = cnt;

        if (item.end_of_column)
        begin
            if (cnt < s)
            begin
                avg.average            = '0;
                avg.last_of_run        = 1'b1;
                avg.short_column_error = 1'b1;
                expected_averages.push_back(avg);
            end
            else
            begin
                // unfilled window slots go first, then the oldest samples drop out
                missing = cnt - w;
                len     = cnt;
                trail   = (write_ptr + MAX_WINDOW - cnt) % MAX_WINDOW;
                repeat (s)
                begin
                    if (missing < 0)
                        missing++;
                    else
                    begin
                        column_sum -= history[trail];
                        trail = (trail + 1) % MAX_WINDOW;
                        len--;
                    end
                    if (len < 1)
                        len = 1;
                    push_average(column_sum, len);
                end
            end
            column_sum        = 0;
            samples_in_window = 0;
        end

        if (expected_averages.size() > queued)
        begin
            avg = expected_averages.pop_back();
            avg.last_of_run = 1'b1;
            expected_averages.push_back(avg);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_item_t exp_avg;
        if (!rst_n)
        begin
            window_reg        = WLEN_RESET;
            shift_reg         = SHIFT_RESET;
            column_sum        = 0;
            samples_in_window = 0;
            write_ptr         = 0;
            mismatch_count    = 0;
            checked_count     = 0;
            expected_averages.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_WINDOW_LEN: window_reg = pwdata[WLEN_BITS-1:0];
                    REG_SHIFT:      shift_reg  = pwdata[SHIFT_BITS-1:0];
                    default:        ;
                endcase
            end

            if (sample_valid && sample_ready)
                predict_averages(sample_data);

            if (result_valid && result_ready)
            begin
                if (expected_averages.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $error("unexpected item: average %0d, last %0b, error %0b",
                               result_data.average, result_data.last_of_run,
                               result_data.short_column_error);
                end
                else
                begin
                    exp_avg = expected_averages.pop_front();
                    checked_count++;
                    if (result_data.average !== exp_avg.average)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $error("average: expected %0d, got %0d",
                                   exp_avg.average, result_data.average);
                    end
                    if (result_data.last_of_run !== exp_avg.last_of_run)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $error("last_of_run: expected %0b, got %0b",
                                   exp_avg.last_of_run, result_data.last_of_run);
                    end
                    if (result_data.short_column_error !== exp_avg.short_column_error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $error("short_column_error: expected %0b, got %0b",
                                   exp_avg.short_column_error,
                                   result_data.short_column_error);
                    end
                end
            end
        end
        pending_count = expected_averages.size();
    end

endmodule

### verif/shifted_moving_average_test.sv
`timescale 1ns / 1ps

module shifted_moving_average_test;
    import sma_pkg::*;

    localparam int MAX_WINDOW  = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 60;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_ready;
    sample_item_t          sample_data;
    logic                  result_valid;
    logic                  result_ready;
    result_item_t          result_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending_averages;
    int averages_checked;

    bit idling;
    bit hold_off_request;
    int cur_window;
    int cur_shift;
    int samples_sent;
    int columns_ended;
    int settings_used;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    shifted_moving_average #(
        .MAX_WINDOW(MAX_WINDOW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    sma_average_checker #(
        .MAX_WINDOW(MAX_WINDOW)
    ) averages_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample_data    (sample_data),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_data    (result_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatches),
        .pending_count  (pending_averages),
        .checked_count  (averages_checked)
    );

    task automatic write_register(input logic index, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // idle phase with psel low before the next transfer
        @(posedge clk);
    endtask

    task automatic set_window(input int window_value, input int shift_value);
        write_register(REG_WINDOW_LEN, window_value);
        write_register(REG_SHIFT, shift_value);
        cur_window = (window_value < 1) ? 1 :
                     (window_value > MAX_WINDOW) ? MAX_WINDOW : window_value;
        cur_shift  = (shift_value < cur_window) ? shift_value : cur_window - 1;
        settings_used++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic eoc);
        sample_item_t item;
        item.sample        = value;
        item.end_of_column = eoc;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= item;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        samples_sent++;
        if (eoc)
            columns_ended++;
    endtask

    // extra cycles cover a sample still in flight that yields no average
    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        wait (pending_averages == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        logic signed [SAMPLE_BITS-1:0] value;
        case ($urandom_range(0, 7))
            0: value = 16'sh7FFF;
            1: value = 16'sh8000;
            2:
            begin
                value = SAMPLE_BITS'($urandom_range(0, 16));
                value = value - 16'sd8;
            end
            default: value = SAMPLE_BITS'($urandom());
        endcase
        return value;
    endfunction

    // receiver: short random stalls, one long hold on request
    initial
    begin
        result_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("shifted_moving_average_test NOT OK");
        $finish;
    end

    initial
    begin
        int phase;
        int budget;
        int len;
        int idx;
        int window_value;

        rst_n            = 1'b0;
        sample_valid     = 1'b0;
        sample_data      = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        idling           = 1'b1;
        hold_off_request = 1'b0;
        cur_window       = 1;
        cur_shift        = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: one-sample window, every sample is its own average
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);

        // fill, ramp-up, full window and flush in one column
        drain_results();
        set_window(4, 2);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        // column ends before the shift is reached
        send_sample(16'sd100, 1'b1);

        // zero window acts as one, shift clamps to zero
        drain_results();
        set_window(0, 5);
        send_sample(-16'sd5, 1'b0);
        send_sample(16'sd7, 1'b1);

        // oversized window clamps to the maximum
        drain_results();
        set_window(127, 63);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);

        // column shorter than the window: divisor holds at the column length
        drain_results();
        set_window(8, 3);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd1, 1'b1);

        // window shrinks in the middle of a column
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sd9, 1'b0);
        drain_results();
        set_window(3, 1);
        send_sample(-16'sd77, 1'b0);
        send_sample(16'sd12, 1'b1);

        for (phase = 0; phase < 10; phase++)
        begin
            drain_results();
            idling = (phase < 8);
            case (phase)
                0: set_window(64, 63);
                1: set_window(1, 0);
                2: set_window(64, 0);
                3: set_window(20, 63);
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        set_window($urandom_range(0, 127), $urandom_range(0, 63));
                    else
                    begin
                        window_value = $urandom_range(1, 12);
                        set_window(window_value, $urandom_range(0, window_value));
                    end
                end
            endcase
            if (phase == 4)
                hold_off_request = 1'b1;
            budget = (phase == 0) ? 100 : 39;
            // a phase may stop mid-column, so the next setting lands inside it
            while (budget > 0)
            begin
                if (cur_shift > 0 && $urandom_range(0, 5) == 0)
                    len = $urandom_range(1, cur_shift);
                else
                    len = $urandom_range(cur_shift + 1, cur_window + cur_shift + 2);
                for (idx = 0; idx < len && budget > 0; idx++)
                begin
                    send_sample(random_sample(), idx == len - 1);
                    budget--;
                end
            end
        end

        drain_results();
        $display("%0d samples sent, %0d columns closed, %0d register settings",
                 samples_sent, columns_ended, settings_used);
        $display("%0d averages checked, incl. ramp-up, flush, short columns and a %0d-cycle hold",
                 averages_checked, LONG_HOLD);
        if (mismatches == 0 && pending_averages == 0)
            $display("shifted_moving_average_test OK");
        else
            $display("shifted_moving_average_test NOT OK");
        $finish;
    end

endmodule
